/* sv/mhls_pkg.sv */
// shared types and constants for the multi-buffer hash lane scheduler
// no dependencies
package mhls_pkg;

    localparam int LANES  = 16;
    localparam int LANE_W = 4;
    localparam int CNT_W  = 5;
    localparam int TAG_W  = 16;
    localparam int BLK_W  = 27;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [0:0] REG_MAX_LANES = 1'b0;

    typedef struct packed {
        logic             busy;
        logic [BLK_W-1:0] rem;
        logic [TAG_W-1:0] tag;
    } lane_t;

    typedef struct packed {
        logic              init;
        logic              pop;
        logic              push;
        logic [LANE_W-1:0] lane;
        logic [CNT_W-1:0]  max_lanes;
    } stack_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [LANE_W-1:0] lane;
        logic [BLK_W-1:0]  run_blocks;
        logic [CNT_W-1:0]  run_lanes;
        logic              wide;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_RUN,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

/* sv/multibuffer_hash_lane_scheduler_unit.sv */
// top level of the multi-buffer hash lane scheduler: ring of lane cells,
// free lane stack, control sequencer, apb register and output register
// depends on mhls_pkg, mhls_cell, mhls_free_stack
//
// usage
// input stream s_*: s_tuser[0] is the operation (0 submit, 1 flush),
//   s_tdata carries the job tag and block count; one transfer per job step
// output stream m_*: exactly one result transfer per input transfer,
//   in order: done flag, tag, lane, run length, run lane count, wide path
// apb port: register max_lanes at address 0, clamped to 1..16; a write
//   clears all lanes, refills the free stack and zeroes the busy count
// sequence: a submit with no free lane skips the ring and goes to the output register;
//   otherwise one pass of the 16-cell lane ring looks for a finished lane and
//   the minimum, plus a second pass when a run is made
// one item is worked at a time; s_tready is high only while idle, and a new
//   item is taken while the previous result still waits in the output register
// a stalled receiver holds the result; the finished item waits until the
//   output register frees up
// reset: max_lanes 16, all lanes idle, free stack holds lanes 0..15, 0 on top
module multibuffer_hash_lane_scheduler_unit
    import mhls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // job_tag[15:0], job_blocks[42:16], zero fill
    input  logic [0:0]  s_tuser,  // op[0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // done_valid[0], done_tag[16:1], done_lane[20:17], run_blocks[47:21],
    // run_lanes[52:48], wide_path[53], zero fill
    output logic [55:0] m_tdata
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  max_lanes_reg;
    logic [CNT_W-1:0]  busy_count_reg;
    logic              op_reg;
    logic [LANE_W-1:0] scan_cnt_reg;
    logic              found_reg;
    logic [LANE_W-1:0] found_lane_reg;
    logic [TAG_W-1:0]  found_tag_reg;
    logic [BLK_W-1:0]  min_reg;
    logic [CNT_W-1:0]  cnt_reg;
    res_t              res_reg, res_next;
    res_t              out_reg;
    logic              m_tvalid_reg;

    lane_t             cell_q  [LANES];
    lane_t             cell_in [LANES];
    lane_t             head, head_mod, ins_data;
    stack_ctl_t        stack_ctl;
    logic [LANE_W-1:0] stack_top;
    logic [CNT_W-1:0]  free_count;

    logic              cfg_wr, accept, no_free, insert, last_step;
    logic              active, scan_hit, run_hit, do_run, release_lane, load_out;
    logic [CNT_W-1:0]  cfg_val;
    logic [CNT_W:0]    wide_sum;
    logic [TAG_W-1:0]  in_tag;
    logic [BLK_W-1:0]  in_blocks;

    // configuration port
    assign pready  = 1'b1;
    assign prdata  = 32'(max_lanes_reg);
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LANES);

    always_comb
    begin
        cfg_val = pwdata[CNT_W-1:0];
        if (cfg_val == '0)
        begin
            cfg_val = CNT_W'(1);
        end
        if (cfg_val > CNT_W'(LANES))
        begin
            cfg_val = CNT_W'(LANES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lanes_reg <= CNT_W'(LANES);
        end
        else if (cfg_wr)
        begin
            max_lanes_reg <= cfg_val;
        end
    end

    // input decode
    assign in_tag    = s_tdata[TAG_W-1:0];
    assign in_blocks = s_tdata[TAG_W+BLK_W-1:TAG_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign no_free   = (free_count == '0);
    assign insert    = accept && (s_tuser[0] == OP_SUBMIT) && !no_free;
    assign last_step = (scan_cnt_reg == LANE_W'(LANES - 1));

    assign ins_data.busy = 1'b1;
    assign ins_data.rem  = in_blocks;
    assign ins_data.tag  = in_tag;

    // head of the ring and the value returned to its tail
    assign head     = cell_q[0];
    assign active   = head.busy && (head.rem != '0);
    assign scan_hit = head.busy && (head.rem == '0) && !found_reg;
    assign run_hit  = active && (head.rem == min_reg) && !found_reg;

    always_comb
    begin
        head_mod = head;
        if (state_reg == ST_SCAN)
        begin
            if (scan_hit)
            begin
                head_mod.busy = 1'b0;
            end
        end
        else
        begin
            if (active)
            begin
                head_mod.rem = head.rem - min_reg;
            end
            if (run_hit)
            begin
                head_mod.busy = 1'b0;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++)
        begin : g_cell
            if (gi == LANES - 1)
            begin : g_tail
                assign cell_in[gi] = head_mod;
            end
            else
            begin : g_body
                assign cell_in[gi] = cell_q[gi+1];
            end

            mhls_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .clear   (cfg_wr),
                .wr      (insert && (stack_top == LANE_W'(gi))),
                .shift   ((state_reg == ST_SCAN) || (state_reg == ST_RUN)),
                .wr_data (ins_data),
                .nb_in   (cell_in[gi]),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    // free lane stack
    assign release_lane = ((state_reg == ST_EVAL) || (state_reg == ST_FIN)) && found_reg;

    assign stack_ctl.init      = cfg_wr;
    assign stack_ctl.pop       = insert;
    assign stack_ctl.push      = release_lane;
    assign stack_ctl.lane      = found_lane_reg;
    assign stack_ctl.max_lanes = cfg_val;

    mhls_free_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stack_ctl),
        .top   (stack_top),
        .count (free_count)
    );

    // sequencer
    assign do_run   = (op_reg == OP_SUBMIT) ? (busy_count_reg >= max_lanes_reg)
                                            : (busy_count_reg != '0);
    assign wide_sum = {1'b0, cnt_reg} + (CNT_W+1)'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((s_tuser[0] == OP_SUBMIT) && no_free)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (found_reg)
                begin
                    res_next       = '0;
                    res_next.valid = 1'b1;
                    res_next.tag   = found_tag_reg;
                    res_next.lane  = found_lane_reg;
                    state_next     = ST_DONE;
                end
                else if (do_run && (cnt_reg != '0))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                res_next.valid      = found_reg;
                res_next.tag        = found_reg ? found_tag_reg : '0;
                res_next.lane       = found_reg ? found_lane_reg : '0;
                res_next.run_blocks = min_reg;
                res_next.run_lanes  = cnt_reg;
                res_next.wide       = (wide_sum >= {1'b0, max_lanes_reg});
                state_next          = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
        end
        else if (accept)
        begin
            scan_cnt_reg <= '0;
        end
        else if ((state_reg == ST_SCAN) || (state_reg == ST_RUN))
        begin
            scan_cnt_reg <= scan_cnt_reg + LANE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            op_reg       <= s_tuser[0];
            found_reg    <= 1'b0;
            cnt_reg      <= '0;
            min_reg      <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (scan_hit)
            begin
                found_reg      <= 1'b1;
                found_lane_reg <= scan_cnt_reg;
                found_tag_reg  <= head.tag;
            end
            if (active)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if ((cnt_reg == '0) || (head.rem < min_reg))
                begin
                    min_reg <= head.rem;
                end
            end
        end
        else if (state_reg == ST_RUN)
        begin
            if (run_hit)
            begin
                found_reg      <= 1'b1;
                found_lane_reg <= scan_cnt_reg;
                found_tag_reg  <= head.tag;
            end
        end
    end

    // busy lane count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            busy_count_reg <= '0;
        end
        else if (insert)
        begin
            busy_count_reg <= busy_count_reg + CNT_W'(1);
        end
        else if (release_lane && (busy_count_reg != '0))
        begin
            busy_count_reg <= busy_count_reg - CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.wide, out_reg.run_lanes, out_reg.run_blocks,
                       out_reg.lane, out_reg.tag, out_reg.valid};

`ifndef SYNTHESIS
    a_lane_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((free_count + busy_count_reg) == max_lanes_reg))
        else $error("free and busy lane counts do not add up to max_lanes");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> ((busy_count_reg == '0) && (free_count == max_lanes_reg)))
        else $error("register write did not re-initialise the lanes");

    a_ring_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (scan_cnt_reg == '0) || !$past(rst_n))
        else $error("lane ring not aligned while idle");

    a_run_has_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((min_reg != '0) && (cnt_reg != '0)))
        else $error("run pass started without a nonzero minimum");
`endif

endmodule

/* sv/mhls_cell.sv */
// one lane cell of the rotating lane ring: busy flag, remaining blocks, tag
// depends on mhls_pkg
module mhls_cell
    import mhls_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  clear,
    input  logic  wr,
    input  logic  shift,
    input  lane_t wr_data,
    input  lane_t nb_in,
    output lane_t q
);

    lane_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (clear)
        begin
            q_reg.busy <= 1'b0;
            q_reg.rem  <= '0;
        end
        else if (wr)
        begin
            q_reg <= wr_data;
        end
        else if (shift)
        begin
            q_reg <= nb_in;
        end
    end

    assign q = q_reg;

endmodule

/* sv/mhls_free_stack.sv */
// lifo stack of free lane numbers with its fill count
// depends on mhls_pkg
module mhls_free_stack
    import mhls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stack_ctl_t        ctl,
    output logic [LANE_W-1:0] top,
    output logic [CNT_W-1:0]  count
);

    logic [LANE_W-1:0] stack_reg [LANES];
    logic [CNT_W-1:0]  count_reg;
    logic [LANE_W-1:0] top_idx;

    assign top_idx = LANE_W'(count_reg - CNT_W'(1));
    assign top     = stack_reg[top_idx];
    assign count   = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(LANES);
            for (int i = 0; i < LANES; i++)
            begin
                stack_reg[i] <= LANE_W'(LANES - 1 - i);
            end
        end
        else if (ctl.init)
        begin
            count_reg <= ctl.max_lanes;
            for (int i = 0; i < LANES; i++)
            begin
                if (CNT_W'(i) < ctl.max_lanes)
                begin
                    stack_reg[i] <= LANE_W'(ctl.max_lanes - CNT_W'(i) - CNT_W'(1));
                end
                else
                begin
                    stack_reg[i] <= '0;
                end
            end
        end
        else if (ctl.push)
        begin
            if (count_reg < CNT_W'(LANES))
            begin
                stack_reg[LANE_W'(count_reg)] <= ctl.lane;
                count_reg <= count_reg + CNT_W'(1);
            end
        end
        else if (ctl.pop)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

/* tb/sv/mhls_checker.sv */
// checker for the multi-buffer hash lane scheduler: watches the apb port and both streams,
// predicts each result from a model of the lanes and the free stack, and compares in order
// depends on mhls_pkg
`timescale 1ns / 1ps

module mhls_checker
    import mhls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,  // job_tag[15:0], job_blocks[42:16], zero fill
    input  logic [0:0]  s_tuser,  // op[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    // done_valid[0], done_tag[16:1], done_lane[20:17], run_blocks[47:21],
    // run_lanes[52:48], wide_path[53], zero fill
    input  logic [55:0] m_tdata,
    output int          fail_cnt,
    output int          outstanding
);

    logic [BLK_W-1:0]  lane_rem  [LANES];
    logic [TAG_W-1:0]  lane_tag  [LANES];
    logic              lane_busy [LANES];
    logic [LANE_W-1:0] free_stk  [LANES];
    int                free_cnt;
    int                busy_cnt;
    int                lanes_max;
    logic [4:0]        cfg_val;

    res_t completion_q[$];
    res_t want;
    res_t got;
    int   in_cnt;
    int   out_cnt;

    assign outstanding = in_cnt - out_cnt;

    function automatic void lanes_init();
        int i;
        for (i = 0; i < LANES; i++)
        begin
            lane_rem[i]  = '0;
            lane_tag[i]  = '0;
            lane_busy[i] = 1'b0;
            free_stk[i]  = '0;
        end
        for (i = 0; i < lanes_max; i++)
            free_stk[i] = LANE_W'(lanes_max - 1 - i);
        free_cnt = lanes_max;
        busy_cnt = 0;
    endfunction

    // frees the lowest busy lane with nothing left, -1 if none
    function automatic int retire_lane();
        int i;
        for (i = 0; i < LANES; i++)
        begin
            if (lane_busy[i] && lane_rem[i] == '0)
            begin
                lane_busy[i] = 1'b0;
                if (free_cnt < LANES)
                begin
                    free_stk[free_cnt] = LANE_W'(i);
                    free_cnt++;
                end
                if (busy_cnt > 0)
                    busy_cnt--;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic res_t schedule_step(input logic op, input logic [TAG_W-1:0] tag,
                                           input logic [BLK_W-1:0] blocks);
        res_t             r;
        int               lane;
        int               slot;
        int               i;
        int               nrun;
        logic             run_en;
        logic [BLK_W-1:0] m;
        r    = '0;
        m    = '0;
        nrun = 0;
        if (op == OP_SUBMIT)
        begin
            if (free_cnt == 0)
                return r;
            free_cnt--;
            slot = free_stk[free_cnt];
            lane_rem[slot]  = blocks;
            lane_tag[slot]  = tag;
            lane_busy[slot] = 1'b1;
            busy_cnt++;
        end
        lane = retire_lane();
        if (lane < 0)
        begin
            run_en = (op == OP_SUBMIT) ? (busy_cnt >= lanes_max) : (busy_cnt > 0);
            if (run_en)
            begin
                for (i = 0; i < LANES; i++)
                begin
                    if (lane_busy[i] && lane_rem[i] != '0)
                    begin
                        if (nrun == 0 || lane_rem[i] < m)
                            m = lane_rem[i];
                        nrun++;
                    end
                end
                if (nrun > 0)
                begin
                    for (i = 0; i < LANES; i++)
                        if (lane_busy[i] && lane_rem[i] != '0)
                            lane_rem[i] = lane_rem[i] - m;
                    r.run_blocks = m;
                    r.run_lanes  = CNT_W'(nrun);
                    r.wide       = (nrun + 2 >= lanes_max);
                end
                lane = retire_lane();
            end
        end
        if (lane >= 0)
        begin
            r.valid = 1'b1;
            r.tag   = lane_tag[lane];
            r.lane  = LANE_W'(lane);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_max = LANES;
            lanes_init();
            completion_q.delete();
            fail_cnt = 0;
            in_cnt  <= 0;
            out_cnt <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LANES)
            begin
                cfg_val = pwdata[4:0];
                if (cfg_val == 0)
                    lanes_max = 1;
                else if (cfg_val > LANES)
                    lanes_max = LANES;
                else
                    lanes_max = cfg_val;
                lanes_init();
            end
            if (s_tvalid && s_tready)
            begin
                completion_q.push_back(schedule_step(s_tuser[0], s_tdata[15:0], s_tdata[42:16]));
                in_cnt <= in_cnt + 1;
            end
            if (m_tvalid && m_tready)
            begin
                out_cnt <= out_cnt + 1;
                got.valid      = m_tdata[0];
                got.tag        = m_tdata[16:1];
                got.lane       = m_tdata[20:17];
                got.run_blocks = m_tdata[47:21];
                got.run_lanes  = m_tdata[52:48];
                got.wide       = m_tdata[53];
                if (completion_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: %0h", m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want = completion_q.pop_front();
                    check_field("done_valid", want.valid, got.valid);
                    check_field("done_tag", want.tag, got.tag);
                    check_field("done_lane", want.lane, got.lane);
                    check_field("run_blocks", want.run_blocks, got.run_blocks);
                    check_field("run_lanes", want.run_lanes, got.run_lanes);
                    check_field("wide_path", want.wide, got.wide);
                end
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// top of the lane scheduler testbench: clock, reset, apb writes, job stimulus and
// result back-pressure around the block, with the verdict taken from mhls_checker
// depends on mhls_pkg, mhls_checker, multibuffer_hash_lane_scheduler_unit
`timescale 1ns / 1ps

module tb_top;
    import mhls_pkg::*;

    localparam logic [0:0] REG_UNUSED  = 1'b1;
    localparam int         STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // job_tag[15:0], job_blocks[42:16], zero fill
    logic [0:0]  s_tuser;   // op[0]
    logic        m_tvalid;
    logic        m_tready;
    // done_valid[0], done_tag[16:1], done_lane[20:17], run_blocks[47:21],
    // run_lanes[52:48], wide_path[53], zero fill
    logic [55:0] m_tdata;
    int          fail_cnt;
    int          outstanding;
    logic        idling_on;
    int          lanes_now;

    multibuffer_hash_lane_scheduler_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mhls_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_cnt    (fail_cnt),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [BLK_W-1:0] pick_blocks();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 45)
            return BLK_W'($urandom_range(1, 3));
        if (sel < 75)
            return BLK_W'($urandom_range(1, 64));
        if (sel < 90)
            return BLK_W'($urandom);
        return '1;
    endfunction

    task automatic send_item(input logic op, input logic [TAG_W-1:0] tag,
                             input logic [BLK_W-1:0] blocks);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, blocks, tag};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_max_lanes(input logic [31:0] value);
        apb_write(REG_MAX_LANES, value);
        if (value[4:0] == 0)
            lanes_now = 1;
        else if (value[4:0] > LANES)
            lanes_now = LANES;
        else
            lanes_now = value[4:0];
    endtask

    // bursts of submits, often followed by a full flush; the rest is single noise items
    task automatic random_jobs(input int n);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                burst = $urandom_range(1, 2 * lanes_now + 1);
                for (k = 0; k < burst; k++)
                begin
                    send_item(OP_SUBMIT, TAG_W'($urandom), pick_blocks());
                    sent++;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    for (k = 0; k < lanes_now + 1; k++)
                    begin
                        send_item(OP_FLUSH, TAG_W'($urandom), BLK_W'($urandom));
                        sent++;
                    end
                end
            end
            else
            begin
                send_item(($urandom_range(0, 1) == 1) ? OP_FLUSH : OP_SUBMIT,
                          TAG_W'($urandom), pick_blocks());
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_SUBMIT;
        idling_on = 1'b1;
        lanes_now = LANES;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flush on empty, zero-block job, tied counts, longest runs
        send_item(OP_FLUSH, 16'h0000, '0);
        send_item(OP_SUBMIT, 16'h0000, '0);
        send_item(OP_SUBMIT, 16'hffff, '1);
        send_item(OP_SUBMIT, 16'h1234, 27'd5);
        send_item(OP_SUBMIT, 16'h00ff, 27'd5);
        send_item(OP_SUBMIT, 16'h5a5a, 27'd2);
        send_item(OP_FLUSH, 16'hffff, '1);
        send_item(OP_FLUSH, 16'h0000, '0);
        send_item(OP_FLUSH, 16'h0000, '0);
        send_item(OP_FLUSH, 16'h0000, '0);
        send_item(OP_FLUSH, 16'h0000, '0);
        send_item(OP_SUBMIT, 16'haaaa, '1);
        send_item(OP_FLUSH, 16'h5555, 27'h2aaaaaa);
        send_item(OP_FLUSH, 16'h0000, '0);
        drain();

        random_jobs(120);
        apb_write(REG_UNUSED, 32'd3);
        random_jobs(40);
        set_max_lanes(32'd0);
        random_jobs(60);
        set_max_lanes(32'd3);
        random_jobs(60);
        set_max_lanes(32'd31);
        random_jobs(100);
        set_max_lanes(32'd5);
        random_jobs(80);
        set_max_lanes(32'd1);
        random_jobs(50);
        set_max_lanes(32'd16);
        idling_on = 1'b0;
        random_jobs(150);

        repeat (40) @(posedge clk);
        if (fail_cnt == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
